@@ src/mbe_pkg.sv @@
package mbe_pkg;

  // Field widths of one request and one result
  localparam int COL_W = 10;
  localparam int ROW_W = 9;
  localparam int CNT_W = 12;

  // Fractional bits of the coordinate registers (Q4.28)
  localparam int REG_FRAC = 28;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_X_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMIT = 3'd5;

  // Register values after reset
  localparam logic [31:0]      RST_X_START   = 32'hE000_0000;
  localparam logic [31:0]      RST_Y_START   = 32'hEC00_0000;
  localparam logic [30:0]      RST_STEP_X    = 31'd1260262;
  localparam logic [30:0]      RST_STEP_Y    = 31'd1401020;
  localparam logic [CNT_W-1:0] RST_MAX_ITER  = 12'd4095;
  localparam logic [31:0]      RST_ESC_LIMIT = 32'd536870912;

  // One queued request: pixel position and its saturated Q4.28 point c
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } mbe_item_t;

endpackage

@@ src/mbe_front.sv @@
module mbe_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mbe_pkg::COL_W-1:0]  in_column,
  input  logic [mbe_pkg::ROW_W-1:0]  in_row,
  input  logic signed [31:0]         x_start,
  input  logic signed [31:0]         y_start,
  input  logic [30:0]                step_x,
  input  logic [30:0]                step_y,
  output logic                       push_valid,
  input  logic                       push_ready,
  output mbe_pkg::mbe_item_t         push_item
);
  import mbe_pkg::*;

  // Form start + idx*step and saturate to the signed 32-bit range
  function automatic logic signed [31:0] coord_sat(logic signed [31:0] start,
                                                   logic [30:0] step,
                                                   logic [COL_W-1:0] idx);
    logic [40:0]        prod;
    logic signed [42:0] sum;
    prod = 41'(idx) * 41'(step);
    sum  = {{11{start[31]}}, start} + {2'b00, prod};
    if (sum[42:31] == {12{sum[42]}}) begin
      return sum[31:0];
    end else if (sum[42]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // Hand the request straight to the queue with its point attached
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_item.column = in_column;
    push_item.row    = in_row;
    push_item.cr     = coord_sat(x_start, step_x, in_column);
    push_item.ci     = coord_sat(y_start, step_y, COL_W'(in_row));
  end

endmodule

@@ src/mbe_queue.sv @@
module mbe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  mbe_pkg::mbe_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mbe_pkg::mbe_item_t pop_item
);
  import mbe_pkg::*;

  mbe_item_t   slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ src/mbe_core.sv @@
module mbe_core #(
  parameter int FRAC_BITS = 28
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  mbe_pkg::mbe_item_t         pop_item,
  input  logic [mbe_pkg::CNT_W-1:0]  max_iter,
  input  logic [31:0]                esc_limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mbe_pkg::CNT_W-1:0]  out_count_left,
  output logic [mbe_pkg::COL_W-1:0]  out_column,
  output logic [mbe_pkg::ROW_W-1:0]  out_row
);
  import mbe_pkg::*;

  localparam int CW = FRAC_BITS + 4;     // c in Q4.F
  localparam int ZW = FRAC_BITS + 3;     // z kept while |x|,|y| < 4
  localparam int PW = 2 * ZW;            // full-width product
  localparam int NW = FRAC_BITS + 8;     // new z before the bound check
  localparam int LIM_SHIFT = 2 * FRAC_BITS - REG_FRAC;

  localparam logic signed [NW-1:0] BOUND_P = {{(NW - FRAC_BITS - 3){1'b0}}, 3'b100,
                                              {FRAC_BITS{1'b0}}};
  localparam logic signed [NW-1:0] BOUND_N = -BOUND_P;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ITER = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     res_r, res_nxt;
  logic                 first_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic signed [CW-1:0] cr_r, ci_r;
  logic signed [CW-1:0] cr_in, ci_in;
  logic signed [ZW-1:0] x_r, y_r;
  logic signed [PW-1:0] xx_r, yy_r, xy_r;
  logic                 out_valid_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic [COL_W-1:0]     out_col_r;
  logic [ROW_W-1:0]     out_row_r;

  logic signed [PW:0]   diff;
  logic signed [NW-1:0] nx, ny;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        limit_w;
  logic                 mag_esc;
  logic                 bound_esc;
  logic [CNT_W-1:0]     n_eff;
  logic                 out_free;

  // Bring the Q4.28 point to FRAC_BITS fractional bits
  if (FRAC_BITS >= REG_FRAC) begin : g_widen
    assign cr_in = CW'(pop_item.cr) <<< (FRAC_BITS - REG_FRAC);
    assign ci_in = CW'(pop_item.ci) <<< (FRAC_BITS - REG_FRAC);
  end else begin : g_narrow
    assign cr_in = CW'(pop_item.cr >>> (REG_FRAC - FRAC_BITS));
    assign ci_in = CW'(pop_item.ci >>> (REG_FRAC - FRAC_BITS));
  end

  // Next z from the registered products, and the escape tests
  assign diff      = (PW + 1)'(xx_r) - (PW + 1)'(yy_r);
  assign nx        = NW'(diff >>> FRAC_BITS) + NW'(cr_r);
  assign ny        = NW'(xy_r >>> (FRAC_BITS - 1)) + NW'(ci_r);
  assign bound_esc = (nx >= BOUND_P) || (nx <= BOUND_N) ||
                     (ny >= BOUND_P) || (ny <= BOUND_N);
  assign mag       = $unsigned(xx_r) + $unsigned(yy_r);
  assign limit_w   = PW'(esc_limit) << LIM_SHIFT;
  assign mag_esc   = !first_r && (mag > limit_w);
  assign n_eff     = first_r ? n_r : n_r - CNT_W'(1);
  assign out_free  = !out_valid_r || out_ready;

  assign pop_ready = (state_r == S_IDLE);

  // Iteration sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = S_ITER;
          n_nxt     = max_iter;
        end
      end
      S_ITER: begin
        if (mag_esc) begin
          res_nxt   = n_r;
          state_nxt = S_DONE;
        end else if (n_eff == '0) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else if (bound_esc) begin
          res_nxt   = n_eff;
          state_nxt = S_DONE;
        end else begin
          n_nxt     = n_eff;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ITER;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          col_r   <= pop_item.column;
          row_r   <= pop_item.row;
          cr_r    <= cr_in;
          ci_r    <= ci_in;
          xx_r    <= '0;
          yy_r    <= '0;
          xy_r    <= '0;
          first_r <= 1'b1;
        end
      end
      S_ITER: begin
        x_r     <= ZW'(nx);
        y_r     <= ZW'(ny);
        first_r <= 1'b0;
      end
      S_MUL: begin
        xx_r <= x_r * x_r;
        yy_r <= y_r * y_r;
        xy_r <= x_r * y_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_cnt_r <= res_r;
          out_col_r <= col_r;
          out_row_r <= row_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_count_left = out_cnt_r;
  assign out_column     = out_col_r;
  assign out_row        = out_row_r;

endmodule

@@ src/mandelbrot_escape_iterator.sv @@
// Each accepted request iterates z up to max_iter times and ends on the magnitude test,
//   on the countdown, or when the new z leaves |x|,|y| < 4.0; its result waits in the
//   output register under back-pressure.
// The iterator takes one pixel at a time; each iteration is a multiply step, then an
//   update and test step.
// Reset (synchronous, active low) empties the queue and the output register and loads
//   the default view: -2.0 - 1.25i, 640 by 480 steps, 4095 iterations, limit 2.0.
module mandelbrot_escape_iterator #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mbe_pkg::COL_W-1:0]            in_column,
  input  logic [mbe_pkg::ROW_W-1:0]            in_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mbe_pkg::CNT_W-1:0]            out_count_left,
  output logic [mbe_pkg::COL_W-1:0]            out_column,
  output logic [mbe_pkg::ROW_W-1:0]            out_row
);
  import mbe_pkg::*;

  logic signed [31:0] x_start_r;
  logic signed [31:0] y_start_r;
  logic [30:0]        step_x_r;
  logic [30:0]        step_y_r;
  logic [CNT_W-1:0]   max_iter_r;
  logic [31:0]        esc_limit_r;

  logic      push_valid, push_ready;
  mbe_item_t push_item;
  logic      pop_valid, pop_ready;
  mbe_item_t pop_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r   <= RST_X_START;
      y_start_r   <= RST_Y_START;
      step_x_r    <= RST_STEP_X;
      step_y_r    <= RST_STEP_Y;
      max_iter_r  <= RST_MAX_ITER;
      esc_limit_r <= RST_ESC_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_START:   x_start_r   <= cfg_wdata;
        CFG_Y_START:   y_start_r   <= cfg_wdata;
        CFG_STEP_X:    step_x_r    <= cfg_wdata[30:0];
        CFG_STEP_Y:    step_y_r    <= cfg_wdata[30:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[CNT_W-1:0];
        CFG_ESC_LIMIT: esc_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: form the point c for each request
  mbe_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_column  (in_column),
    .in_row     (in_row),
    .x_start    (x_start_r),
    .y_start    (y_start_r),
    .step_x     (step_x_r),
    .step_y     (step_y_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between front and iterator
  mbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: escape-time iteration
  mbe_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .max_iter       (max_iter_r),
    .esc_limit      (esc_limit_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_count_left (out_count_left),
    .out_column     (out_column),
    .out_row        (out_row)
  );

endmodule
